// File: hdl/lts_pkg.sv
// shared types, constants and the ln(1+p) table for the log transform block
// no dependencies; used by lts_ctrl, lts_datapath, the top level and the testbench through scoped names
package lts_pkg;

	localparam int PIX_W         = 8;
	localparam int GAIN_W        = 21;
	localparam int GAIN_FRAC     = 12;
	localparam int LOG_FRAC_BITS = 12;
	localparam int ROM_W         = 16;
	localparam int PROD_W        = GAIN_W + ROM_W;
	localparam int MAX_PIXELS    = 65536;
	localparam int ADDR_W        = $clog2(MAX_PIXELS);
	localparam int CNT_W         = ADDR_W + 1;
	localparam int SHIFT         = GAIN_FRAC + LOG_FRAC_BITS;
	localparam int DIV_STEPS     = PIX_W;
	localparam int STEP_W        = $clog2(DIV_STEPS);

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(188370);
	localparam logic [PIX_W-1:0]  PIX_MAX    = '1;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;

	// request kinds carried on tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_STORE,
		S_RD,
		S_PREP,
		S_DIV,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic mul;
		logic store;
		logic rd_issue;
		logic prep;
		logic div_step;
		logic result_load;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rd_err;
	} dp_status_t;

	typedef logic [ROM_W-1:0] log_rom_t [256];

	// shift-subtract division, evaluated only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// ln(n) by the atanh series in Q30, rounded to LOG_FRAC_BITS fraction bits
	function automatic logic [ROM_W-1:0] ln_entry(input logic [8:0] n);
		logic [63:0] k;
		logic [63:0] m;
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		k = '0;
		sum = '0;
		for (int b = 0; b < 9; b++) begin
			if (n[b]) begin
				k = 64'(b);
			end
		end
		m = ({55'd0, n} << 30) >> k;
		z = udiv64((m - Q30_ONE) << 30, m + Q30_ONE);
		z2 = (z * z) >> 30;
		term = z;
		for (int i = 0; i < 16; i++) begin
			sum = sum + udiv64(term, 64'(2 * i + 1));
			term = (term * z2) >> 30;
		end
		v = k * LN2_Q30 + (sum << 1);
		v = (v + (64'd1 << (29 - LOG_FRAC_BITS))) >> (30 - LOG_FRAC_BITS);
		return v[ROM_W-1:0];
	endfunction

	function automatic log_rom_t build_log_rom();
		log_rom_t t;
		for (int p = 0; p < 256; p++) begin
			t[p] = ln_entry(9'(p + 1));
		end
		return t;
	endfunction

	localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

// File: hdl/lts_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module lts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/lts_ctrl.sv
// controller state machine: request sequencing, divider step count, result valid
// depends on lts_pkg
module lts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tuser,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  lts_pkg::dp_status_t status,
	output lts_pkg::ctrl_cmd_t  cmd
);

	lts_pkg::state_t state_q;
	lts_pkg::state_t state_d;
	logic [lts_pkg::STEP_W-1:0] step_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lts_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == lts_pkg::OP_READ) ? lts_pkg::S_RD : lts_pkg::S_MUL;
				end
			end
			lts_pkg::S_MUL:   state_d = lts_pkg::S_STORE;
			lts_pkg::S_STORE: state_d = lts_pkg::S_IDLE;
			lts_pkg::S_RD: begin
				state_d = status.rd_err ? lts_pkg::S_DONE : lts_pkg::S_PREP;
			end
			lts_pkg::S_PREP:  state_d = lts_pkg::S_DIV;
			lts_pkg::S_DIV: begin
				if (step_q == lts_pkg::STEP_W'(lts_pkg::DIV_STEPS - 1)) begin
					state_d = lts_pkg::S_DONE;
				end
			end
			lts_pkg::S_DONE: begin
				if (out_free) begin
					state_d = lts_pkg::S_IDLE;
				end
			end
			default: state_d = lts_pkg::S_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			lts_pkg::S_IDLE: begin
				s_tready = 1'b1;
				cmd.capture = s_tvalid;
			end
			lts_pkg::S_MUL:   cmd.mul = 1'b1;
			lts_pkg::S_STORE: cmd.store = 1'b1;
			lts_pkg::S_RD:    cmd.rd_issue = 1'b1;
			lts_pkg::S_PREP:  cmd.prep = 1'b1;
			lts_pkg::S_DIV:   cmd.div_step = 1'b1;
			lts_pkg::S_DONE:  cmd.result_load = out_free;
			default: cmd = '0;
		endcase
	end

	// state, step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lts_pkg::S_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// File: hdl/lts_datapath.sv
// datapath: log mapping, frame store, min/max tracking, serial divider, result register
// depends on lts_pkg and lts_ram
module lts_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lts_pkg::ctrl_cmd_t           cmd,
	output lts_pkg::dp_status_t          status,
	input  logic [lts_pkg::PIX_W-1:0]    pixel_in,
	input  logic                         last_pixel,
	input  logic [lts_pkg::ADDR_W-1:0]   read_index,
	input  logic                         cfg_valid,
	input  logic [lts_pkg::GAIN_W-1:0]   cfg_data,
	output logic [lts_pkg::PIX_W-1:0]    pixel_out,
	output logic                         index_error
);

	logic [lts_pkg::GAIN_W-1:0] gain_q;
	logic [lts_pkg::ROM_W-1:0]  log_q;
	logic                       last_q;
	logic [lts_pkg::ADDR_W-1:0] idx_q;
	logic [lts_pkg::PROD_W-1:0] prod_q;

	logic [lts_pkg::CNT_W-1:0]  count_q;
	logic [lts_pkg::PIX_W-1:0]  min_q;
	logic [lts_pkg::PIX_W-1:0]  max_q;
	logic                       done_q;

	logic                       err_q;
	logic                       flat_q;
	logic [lts_pkg::PIX_W-1:0]  den_q;
	logic [lts_pkg::PIX_W-1:0]  rem_q;
	logic [lts_pkg::PIX_W-1:0]  quo_q;
	logic [lts_pkg::PIX_W-1:0]  pixel_out_q;
	logic                       err_out_q;

	logic [lts_pkg::CNT_W-1:0]  cnt_b;
	logic [lts_pkg::PIX_W-1:0]  min_b;
	logic [lts_pkg::PIX_W-1:0]  max_b;
	logic [lts_pkg::PIX_W-1:0]  mapped;
	logic                       room;
	logic                       wr_en;
	logic [lts_pkg::PIX_W-1:0]  rd_data;
	logic [lts_pkg::PIX_W-1:0]  diff;
	logic [2*lts_pkg::PIX_W-1:0] num;
	logic [lts_pkg::PIX_W:0]    trial;
	logic                       ge;

	// gain register, written from the configuration channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= lts_pkg::GAIN_RESET;
		end else if (cfg_valid) begin
			gain_q <= cfg_data;
		end
	end

	// request capture with table lookup, then the gain multiply
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			log_q <= lts_pkg::LOG_ROM[pixel_in];
			last_q <= last_pixel;
			idx_q <= read_index;
		end
		if (cmd.mul) begin
			prod_q <= lts_pkg::PROD_W'(gain_q) * lts_pkg::PROD_W'(log_q);
		end
	end

	// saturate the scaled product to a pixel
	assign mapped = (prod_q[lts_pkg::PROD_W-1:lts_pkg::SHIFT+lts_pkg::PIX_W] != '0)
		? lts_pkg::PIX_MAX : prod_q[lts_pkg::SHIFT +: lts_pkg::PIX_W];

	// a load after a completed frame starts a new one
	assign cnt_b = done_q ? '0 : count_q;
	assign min_b = done_q ? lts_pkg::PIX_MAX : min_q;
	assign max_b = done_q ? '0 : max_q;
	assign room  = cnt_b < lts_pkg::CNT_W'(lts_pkg::MAX_PIXELS);
	assign wr_en = cmd.store && room;

	// frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q <= lts_pkg::PIX_MAX;
			max_q <= '0;
			done_q <= 1'b0;
		end else if (cmd.store) begin
			count_q <= room ? cnt_b + 1'b1 : cnt_b;
			min_q <= (room && mapped < min_b) ? mapped : min_b;
			max_q <= (room && mapped > max_b) ? mapped : max_b;
			done_q <= last_q;
		end
	end

	lts_ram #(
		.WIDTH(lts_pkg::PIX_W),
		.DEPTH(lts_pkg::MAX_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_b[lts_pkg::ADDR_W-1:0]),
		.wdata (mapped),
		.re    (cmd.rd_issue),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	// read check against the completed frame
	assign status.rd_err = !done_q || ({1'b0, idx_q} >= count_q);

	// stretch numerator (v - min) * 255 as a shift and subtract
	assign diff = rd_data - min_q;
	assign num  = {diff, {lts_pkg::PIX_W{1'b0}}} - {{lts_pkg::PIX_W{1'b0}}, diff};

	// restoring divider step, one quotient bit a cycle
	assign trial = {rem_q, quo_q[lts_pkg::PIX_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			err_q <= status.rd_err;
		end
		if (cmd.prep) begin
			flat_q <= (max_q <= min_q) || (rd_data < min_q);
			den_q <= max_q - min_q;
			rem_q <= num[2*lts_pkg::PIX_W-1:lts_pkg::PIX_W];
			quo_q <= num[lts_pkg::PIX_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= ge ? lts_pkg::PIX_W'(trial - {1'b0, den_q}) : trial[lts_pkg::PIX_W-1:0];
			quo_q <= {quo_q[lts_pkg::PIX_W-2:0], ge};
		end
		if (cmd.result_load) begin
			pixel_out_q <= (err_q || flat_q) ? '0 : quo_q;
			err_out_q <= err_q;
		end
	end

	assign pixel_out   = pixel_out_q;
	assign index_error = err_out_q;

endmodule

// File: hdl/log_transform_contrast_stretch.sv
// top level of the log transform and contrast stretch block
// depends on lts_pkg, lts_ctrl, lts_datapath (which holds lts_ram)
//
// Usage:
//   s_* channel takes requests: tuser = 0 loads the next pixel of the frame
//   (tdata[7:0], tlast ends the frame), tuser = 1 reads the stretched pixel
//   at tdata[23:8]. Loads give no result; each read gives one result on the
//   m_* channel: tdata = stretched pixel, tuser = index error.
//   cfg_* writes the Q9.12 log gain; it is always ready and is meant to be
//   written only while no request is in flight.
// Timing:
//   one request at a time, sequenced by the controller. A load passes through
//   capture with table lookup, multiply and store. A read passes through
//   capture, memory read, numerator, 8 divider steps and result load; the
//   result load waits for the output register to be free, and the next request
//   is taken after it. A failed read skips the numerator and the divider steps.
// Reset and stalls:
//   reset clears the frame count, min/max and the done flag and restores the
//   default gain; the frame memory is not cleared. A finished result waits in
//   the output register, so a stalled receiver only holds up the next read.
module log_transform_contrast_stretch (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [7:0] pixel_in, [23:8] read_index
	input  logic [0:0]  s_tuser,  // [0] operation
	input  logic        s_tlast,  // last_pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] pixel_out
	output logic [0:0]  m_tuser,  // [0] index_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [20:0] cfg_data
);

	lts_pkg::ctrl_cmd_t  cmd;
	lts_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	lts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser[0]),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lts_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.pixel_in    (s_tdata[7:0]),
		.last_pixel  (s_tlast),
		.read_index  (s_tdata[23:8]),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.pixel_out   (m_tdata),
		.index_error (m_tuser[0])
	);

endmodule

// File: hdl/lts_checker.sv
// port-level checks for the log transform block, bound to the top level
// depends only on the top level's ports
module lts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an error result carries a zero pixel
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
		else $error("error result with nonzero pixel");

	// one request at a time: ready drops after an accepted request
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// a new result appears as the controller returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result raised outside idle");

endmodule

bind log_transform_contrast_stretch lts_checker u_lts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/log_transform_contrast_stretch_tb.sv
// testbench for log_transform_contrast_stretch: loads, reads, gain writes, stalls
// depends on lts_pkg for the frame depth, request kinds and the default gain; predicts results itself
`timescale 1ns / 100ps

module log_transform_contrast_stretch_tb;

	localparam int          CLK_HALF    = 6;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          HOLD_CYCLES = 400;
	localparam int          SETTLE      = 20;
	localparam int          TAB_FRAC    = 12;
	localparam int          MAP_SHIFT   = 12 + TAB_FRAC;
	localparam int          STORE_DEPTH = lts_pkg::MAX_PIXELS;
	localparam logic [20:0] GAIN_TOP    = '1;
	localparam longint unsigned ONE_Q30    = 64'd1 << 30;
	localparam longint unsigned LN2_AT_Q30 = 64'd744261118;

	typedef struct packed {
		logic [7:0] pix;
		logic       err;
	} stretch_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // [7:0] pixel_in, [23:8] read_index
	logic [0:0]  s_tuser   = '0;   // [0] operation
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // [7:0] pixel_out
	logic [0:0]  m_tuser;          // [0] index_error
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [20:0] cfg_data  = '0;

	// predictor state
	logic [15:0] ln_tab [256];
	logic [7:0]  img_mem [STORE_DEPTH];
	int unsigned img_count;
	logic [7:0]  img_min;
	logic [7:0]  img_max;
	logic        img_done;
	logic [20:0] gain_q;

	stretch_result_t expected_pixels [$];

	int          mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int          n_requests     = 0;
	int          n_results      = 0;
	int          n_gains        = 0;
	int          send_idle_pct  = 0;
	int          recv_idle_pct  = 0;
	logic        hold_start     = 1'b0;
	int          hold_left      = 0;

	log_transform_contrast_stretch dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever begin
			#CLK_HALF clk = ~clk;
		end
	end

	// ln(n) in Q30 by the atanh series, rounded to the table's fraction bits
	function automatic logic [15:0] ln_q12(int unsigned n);
		longint unsigned m;
		longint unsigned z;
		longint unsigned z2;
		longint unsigned term;
		longint unsigned acc;
		longint unsigned v;
		int unsigned     k;
		k = 0;
		acc = 0;
		while ((n >> (k + 1)) != 0) begin
			k++;
		end
		m = (64'(n) << 30) >> k;
		z = ((m - ONE_Q30) << 30) / (m + ONE_Q30);
		z2 = (z * z) >> 30;
		term = z;
		for (int i = 0; i < 16; i++) begin
			acc = acc + term / 64'(2 * i + 1);
			term = (term * z2) >> 30;
		end
		v = 64'(k) * LN2_AT_Q30 + 2 * acc;
		v = (v + (64'd1 << (29 - TAB_FRAC))) >> (30 - TAB_FRAC);
		return v[15:0];
	endfunction

	function automatic void clear_frame();
		img_count = 0;
		img_min = 8'd255;
		img_max = 8'd0;
		img_done = 1'b0;
	endfunction

	// expected effect of one accepted request
	function automatic void predict_request(logic op, logic [7:0] pix, logic last,
			logic [15:0] idx);
		longint unsigned prod;
		logic [7:0]      mapped;
		int unsigned     v;
		int unsigned     r;
		stretch_result_t res;
		if (op == lts_pkg::OP_LOAD) begin
			if (img_done) begin
				clear_frame();
			end
			if (img_count < STORE_DEPTH) begin
				prod = (64'(gain_q) * 64'(ln_tab[pix])) >> MAP_SHIFT;
				mapped = (prod > 255) ? 8'd255 : prod[7:0];
				img_mem[img_count] = mapped;
				img_count++;
				if (mapped < img_min) begin
					img_min = mapped;
				end
				if (mapped > img_max) begin
					img_max = mapped;
				end
			end
			if (last) begin
				img_done = 1'b1;
			end
		end else if (!img_done || idx >= img_count) begin
			res.pix = 8'd0;
			res.err = 1'b1;
			expected_pixels.push_back(res);
		end else begin
			v = img_mem[idx];
			r = 0;
			if (img_max > img_min && v >= img_min) begin
				r = ((v - img_min) * 255) / (img_max - img_min);
			end
			res.pix = r[7:0];
			res.err = 1'b0;
			expected_pixels.push_back(res);
		end
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < 30) begin
			$display("MISMATCH @%0t: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	// one request on the slave side, with an optional gap in front
	task automatic send_request(logic op, logic [7:0] pix, logic last, logic [15:0] idx);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {idx, pix};
		s_tuser  <= op;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		n_requests++;
		predict_request(op, pix, last, idx);
	endtask

	task automatic load_pixel(logic [7:0] pix, logic last);
		send_request(lts_pkg::OP_LOAD, pix, last, 16'($urandom));
	endtask

	task automatic read_pixel(logic [15:0] idx);
		send_request(lts_pkg::OP_READ, 8'($urandom), 1'($urandom), idx);
	endtask

	// stop sending, collect all results, then let a trailing load finish
	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_gain(logic [20:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gain_q = value;
		n_gains++;
	endtask

	// random read index: mostly inside the frame, sometimes past the count
	task automatic read_somewhere();
		logic [15:0] idx;
		if (img_count != 0 && $urandom_range(99) < 85) begin
			idx = 16'($urandom_range(img_count - 1));
		end else if (img_count < STORE_DEPTH) begin
			idx = 16'($urandom_range(STORE_DEPTH - 1, img_count));
		end else begin
			idx = 16'($urandom);
		end
		read_pixel(idx);
	endtask

	// extremes, reads before and after completion, past the count, flat frame
	task automatic test_directed();
		send_idle_pct = 20;
		recv_idle_pct = 20;
		read_pixel(16'd0);
		load_pixel(8'd0, 1'b0);
		load_pixel(8'd255, 1'b0);
		load_pixel(8'd128, 1'b0);
		load_pixel(8'd1, 1'b0);
		read_pixel(16'd1);
		load_pixel(8'd200, 1'b1);
		for (int i = 0; i < 5; i++) begin
			read_pixel(16'(i));
		end
		read_pixel(16'd5);
		read_pixel(16'hFFFF);
		load_pixel(8'd77, 1'b1);
		read_pixel(16'd0);
		read_pixel(16'd1);
		drain_and_settle();
	endtask

	// gain extremes and a few between, each over a short frame
	task automatic test_gain_settings();
		logic [20:0] gains [5];
		logic [7:0]  pixs  [8];
		gains = '{21'd0, GAIN_TOP, 21'd1, 21'd4096, lts_pkg::GAIN_RESET};
		pixs  = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd64, 8'd3, 8'd17};
		send_idle_pct = 10;
		recv_idle_pct = 10;
		foreach (gains[g]) begin
			write_gain(gains[g]);
			foreach (pixs[p]) begin
				load_pixel(pixs[p], p == 7);
			end
			for (int i = 0; i < 9; i++) begin
				read_pixel(16'(i));
			end
			drain_and_settle();
		end
	endtask

	// long receiver hold-off while requests keep coming
	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		for (int i = 0; i < 6; i++) begin
			load_pixel(8'($urandom), i == 5);
		end
		repeat (12) read_somewhere();
		drain_and_settle();
	endtask

	// well-formed frames with random content, plus stray requests
	task automatic test_random_phase(int n_items, int s_pct, int r_pct, logic [20:0] gain);
		int          sent;
		int          len;
		int          style;
		int          nreads;
		logic [7:0]  base;
		logic [7:0]  pix;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		write_gain(gain);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 8) begin
				send_request(1'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
				sent++;
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(150, 25) : $urandom_range(20, 1);
				style = $urandom_range(2);
				base = 8'($urandom_range(252));
				for (int i = 0; i < len; i++) begin
					case (style)
						0: pix = 8'($urandom);
						1: pix = base + 8'($urandom_range(3));
						default: pix = base;
					endcase
					load_pixel(pix, i == len - 1);
					if (i != len - 1 && $urandom_range(99) < 5) begin
						read_somewhere();
						sent++;
					end
				end
				nreads = $urandom_range(len + 3, 1);
				repeat (nreads) read_somewhere();
				sent += len + nreads;
			end
		end
		drain_and_settle();
	endtask

	// receiver readiness, with a counted hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_start) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		stretch_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected result pixel %0d err %0d",
					m_tdata, m_tuser));
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata !== want.pix) begin
					report_mismatch($sformatf("result %0d pixel %0d, expected %0d",
						n_results, m_tdata, want.pix));
				end
				if (m_tuser[0] !== want.err) begin
					report_mismatch($sformatf("result %0d index error %0d, expected %0d",
						n_results, m_tuser, want.err));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		for (int p = 0; p < 256; p++) begin
			ln_tab[p] = ln_q12(p + 1);
		end
		clear_frame();
		gain_q = lts_pkg::GAIN_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_gain_settings();
		test_output_stall();
		test_random_phase(240, 14, 57, 21'($urandom_range(300000, 100000)));
		test_random_phase(240, 57, 14, 21'($urandom_range(GAIN_TOP)));
		test_random_phase(250, 0, 0, lts_pkg::GAIN_RESET);

		if (expected_pixels.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
		end
		$display("run covered %0d requests and %0d results over %0d gain settings,",
			n_requests, n_results, n_gains);
		$display("including flat frames, reads out of range and a long output stall");
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/lts_pkg.sv
hdl/lts_ram.sv
hdl/lts_ctrl.sv
hdl/lts_datapath.sv
hdl/log_transform_contrast_stretch.sv
hdl/lts_checker.sv
tb/log_transform_contrast_stretch_tb.sv
